/* design/ntp_rte_pkg.sv */
`default_nettype none

package ntp_rte_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [5:0]  FULL_LENGTH     = 6'd48;
    localparam logic [5:0]  STAMP_SEC_FIRST = 6'd40;
    localparam logic [5:0]  STAMP_SEC_LAST  = 6'd43;
    localparam logic [5:0]  STAMP_FRC_FIRST = 6'd44;
    localparam logic [5:0]  STAMP_FRC_LAST  = 6'd47;
    localparam logic [5:0]  POS_HEADER      = 6'd0;
    localparam logic [5:0]  POS_STRATUM     = 6'd1;

    localparam logic [2:0]  MODE_SERVER     = 3'd4;
    localparam logic [7:0]  STRATUM_MIN     = 8'd1;
    localparam logic [7:0]  STRATUM_MAX     = 8'd15;

    localparam logic [31:0] EPOCH_GAP_SECS  = 32'd2208988800;
    localparam logic [19:0] US_PER_SECOND   = 20'd1000000;
    localparam logic [8:0]  US_PER_HALF_MS  = 9'd500;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_MODE        = 3'd2,
        ST_STRATUM     = 3'd3,
        ST_BEFORE_1970 = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_last;
        logic [11:0] round_trip_ms;
    } t_in_beat;

    typedef struct packed {
        logic        time_valid;
        logic [2:0]  status;
        logic [30:0] unix_seconds;
        logic [19:0] microseconds;
    } t_out_beat;

    // One finished reply, classified, handed from the front to the back.
    typedef struct packed {
        t_status     status;
        logic [31:0] seconds;
        logic [31:0] fraction;
        logic [11:0] round_trip_ms;
    } t_job;

endpackage

`default_nettype wire

/* design/ntp_reply_time_extractor.sv */
// A reply of any length gives its result through a small job queue and a three-stage
// arithmetic pipeline (stage 1, stage 2, result beat) once its last byte is accepted.
// Throughput: one payload byte per cycle while full is low.
// full rises only when the job queue holds QUEUE_DEPTH unfinished replies.
// Reset is synchronous and active low; it clears the byte count, queue and
// pipeline valids, and needs no clearing pass.
`default_nettype none

module ntp_reply_time_extractor
    import ntp_rte_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_beat i_item,
    output logic          empty,
    input  wire logic     pop,
    output t_out_beat     o_result
);

    logic w_accept;
    logic w_job_push;
    logic w_job_pop;
    logic w_q_full;
    logic w_q_empty;
    t_job w_job_in;
    t_job w_job_out;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    ntp_rte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    ntp_rte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_q_full),
        .i_pop   (w_job_pop),
        .o_empty (w_q_empty),
        .o_job   (w_job_out)
    );

    ntp_rte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    a_valid_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.time_valid == (o_result.status == ST_OK)))
        else $error("time_valid disagrees with status");

    a_failed_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.time_valid) |->
            (o_result.unix_seconds == 31'd0 && o_result.microseconds == 20'd0))
        else $error("failed reply carries nonzero time fields");

    a_us_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.microseconds < US_PER_SECOND))
        else $error("microseconds not reduced below one second");

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status <= ST_BEFORE_1970))
        else $error("status code out of range");

endmodule

`default_nettype wire

/* design/ntp_rte_front.sv */
`default_nettype none

module ntp_rte_front
    import ntp_rte_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_beat i_item,
    output logic          o_job_push,
    output t_job          o_job
);

    logic [5:0]  r_pos,      n_pos;
    logic [7:0]  r_header,   n_header;
    logic [7:0]  r_stratum,  n_stratum;
    logic [31:0] r_seconds,  n_seconds;
    logic [31:0] r_fraction, n_fraction;
    logic [5:0]  w_pos_inc;
    t_status     w_status;

    always_comb begin
        n_header   = r_header;
        n_stratum  = r_stratum;
        n_seconds  = r_seconds;
        n_fraction = r_fraction;
        w_pos_inc  = r_pos;
        if (r_pos < FULL_LENGTH) begin
            w_pos_inc = r_pos + 6'd1;
            if (r_pos == POS_HEADER) begin
                n_header = i_item.payload_byte;
            end
            if (r_pos == POS_STRATUM) begin
                n_stratum = i_item.payload_byte;
            end
            // Timestamp words are big-endian; the low two position bits pick the lane.
            if (r_pos >= STAMP_SEC_FIRST && r_pos <= STAMP_SEC_LAST) begin
                unique case (r_pos[1:0])
                    2'd0: n_seconds[31:24] = i_item.payload_byte;
                    2'd1: n_seconds[23:16] = i_item.payload_byte;
                    2'd2: n_seconds[15:8]  = i_item.payload_byte;
                    2'd3: n_seconds[7:0]   = i_item.payload_byte;
                    default: n_seconds = r_seconds;
                endcase
            end
            if (r_pos >= STAMP_FRC_FIRST && r_pos <= STAMP_FRC_LAST) begin
                unique case (r_pos[1:0])
                    2'd0: n_fraction[31:24] = i_item.payload_byte;
                    2'd1: n_fraction[23:16] = i_item.payload_byte;
                    2'd2: n_fraction[15:8]  = i_item.payload_byte;
                    2'd3: n_fraction[7:0]   = i_item.payload_byte;
                    default: n_fraction = r_fraction;
                endcase
            end
        end

        priority if (w_pos_inc < FULL_LENGTH) begin
            w_status = ST_SHORT;
        end else if (n_header[2:0] != MODE_SERVER) begin
            w_status = ST_MODE;
        end else if (n_stratum < STRATUM_MIN || n_stratum > STRATUM_MAX) begin
            w_status = ST_STRATUM;
        end else if (n_seconds < EPOCH_GAP_SECS) begin
            w_status = ST_BEFORE_1970;
        end else begin
            w_status = ST_OK;
        end

        n_pos = i_item.is_last ? 6'd0 : w_pos_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 6'd0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    // Every captured field is rewritten before a full-length reply can use it.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_header   <= n_header;
            r_stratum  <= n_stratum;
            r_seconds  <= n_seconds;
            r_fraction <= n_fraction;
        end
    end

    assign o_job_push          = i_accept && i_item.is_last;
    assign o_job.status        = w_status;
    assign o_job.seconds       = n_seconds;
    assign o_job.fraction      = n_fraction;
    assign o_job.round_trip_ms = i_item.round_trip_ms;

endmodule

`default_nettype wire

/* design/ntp_rte_queue.sv */
`default_nettype none

module ntp_rte_queue
    import ntp_rte_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* design/ntp_rte_back.sv */
`default_nettype none

module ntp_rte_back
    import ntp_rte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_beat o_result
);

    logic        w_advance;

    // Stage 1: offset removal and the two products.
    logic        r_v1;
    t_status     r_st1;
    logic [30:0] r_secs1;
    logic [19:0] r_frac_us1;
    logic [20:0] r_half_rt1;
    logic [51:0] w_frac_prod;
    logic [31:0] w_secs_diff;

    // Stage 2: microsecond sum.
    logic        r_v2;
    t_status     r_st2;
    logic [30:0] r_secs2;
    logic [21:0] r_us_sum2;

    // Stage 3: carry into seconds, result beat.
    logic        r_out_valid;
    t_out_beat   r_out, n_out;
    logic [1:0]  w_carry;
    logic [21:0] w_us_sub;
    logic [21:0] w_us_rem;

    assign w_advance   = !r_out_valid || i_pop;
    assign o_job_pop   = w_advance && i_job_valid;
    assign w_frac_prod = {20'd0, i_job.fraction} * {32'd0, US_PER_SECOND};
    assign w_secs_diff = i_job.seconds - EPOCH_GAP_SECS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_v1        <= i_job_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_st1      <= i_job.status;
            r_secs1    <= w_secs_diff[30:0];
            r_frac_us1 <= w_frac_prod[51:32];
            r_half_rt1 <= {9'd0, i_job.round_trip_ms} * {12'd0, US_PER_HALF_MS};

            r_st2      <= r_st1;
            r_secs2    <= r_secs1;
            r_us_sum2  <= {2'd0, r_frac_us1} + {1'b0, r_half_rt1};

            r_out      <= n_out;
        end
    end

    // The sum stays below four seconds' worth, so the carry is at most three.
    always_comb begin
        priority if (r_us_sum2 >= 22'(3 * 1000000)) begin
            w_carry  = 2'd3;
            w_us_sub = 22'(3 * 1000000);
        end else if (r_us_sum2 >= 22'(2 * 1000000)) begin
            w_carry  = 2'd2;
            w_us_sub = 22'(2 * 1000000);
        end else if (r_us_sum2 >= {2'd0, US_PER_SECOND}) begin
            w_carry  = 2'd1;
            w_us_sub = {2'd0, US_PER_SECOND};
        end else begin
            w_carry  = 2'd0;
            w_us_sub = 22'd0;
        end
        w_us_rem = r_us_sum2 - w_us_sub;

        n_out.time_valid = (r_st2 == ST_OK);
        n_out.status     = r_st2;
        if (r_st2 == ST_OK) begin
            n_out.unix_seconds = r_secs2 + {29'd0, w_carry};
            n_out.microseconds = w_us_rem[19:0];
        end else begin
            n_out.unix_seconds = 31'd0;
            n_out.microseconds = 20'd0;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
    import ntp_rte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_BEATS  = 300;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_beat  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_beat o_result;

    // Payload beats waiting to be sent; a set flag makes the sender wait for an
    // empty expectation queue before that beat goes out.
    t_in_beat  reply_bytes[$];
    bit        settle_first[$];
    t_out_beat expected_times[$];

    // Shadow of the block's per-reply capture state.
    logic [5:0]  pos_cnt    = '0;
    logic [7:0]  hdr_byte   = '0;
    logic [7:0]  strat_byte = '0;
    logic [31:0] stamp_sec  = '0;
    logic [31:0] stamp_frac = '0;

    int   total_items = 0;
    int   sent_cnt    = 0;
    int   miss_cnt    = 0;
    int   send_gap    = 0;
    int   take_gap    = 0;
    int   idle_pct    = 0;
    int   phase_cnt   = 0;
    int   stall_cnt   = 0;
    logic quiet_tail  = 1'b0;

    ntp_reply_time_extractor uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // Tracks one accepted payload byte; on the last byte it queues the
    // expected time stamp or error status.
    task automatic advance_reply_state(input t_in_beat b);
        t_status     st;
        logic [63:0] secs64;
        logic [63:0] us64;
        t_out_beat   want;
        int          sh;
        if (pos_cnt < FULL_LENGTH) begin
            if (pos_cnt == POS_HEADER) begin
                hdr_byte = b.payload_byte;
            end else if (pos_cnt == POS_STRATUM) begin
                strat_byte = b.payload_byte;
            end else if (pos_cnt >= STAMP_SEC_FIRST && pos_cnt <= STAMP_SEC_LAST) begin
                sh = 8 * int'(STAMP_SEC_LAST - pos_cnt);
                stamp_sec[sh +: 8] = b.payload_byte;
            end else if (pos_cnt >= STAMP_FRC_FIRST && pos_cnt <= STAMP_FRC_LAST) begin
                sh = 8 * int'(STAMP_FRC_LAST - pos_cnt);
                stamp_frac[sh +: 8] = b.payload_byte;
            end
            pos_cnt++;
        end
        if (!b.is_last) return;
        secs64 = '0;
        us64   = '0;
        if (pos_cnt < FULL_LENGTH) begin
            st = ST_SHORT;
        end else if (hdr_byte[2:0] != MODE_SERVER) begin
            st = ST_MODE;
        end else if (strat_byte < STRATUM_MIN || strat_byte > STRATUM_MAX) begin
            st = ST_STRATUM;
        end else if (stamp_sec < EPOCH_GAP_SECS) begin
            st = ST_BEFORE_1970;
        end else begin
            st = ST_OK;
            secs64 = 64'(stamp_sec) - 64'(EPOCH_GAP_SECS);
            us64   = (64'(stamp_frac) * 64'(US_PER_SECOND)) >> 32;
            us64   = us64 + 64'(b.round_trip_ms) * 64'(US_PER_HALF_MS);
            secs64 = secs64 + us64 / 64'(US_PER_SECOND);
            us64   = us64 % 64'(US_PER_SECOND);
        end
        pos_cnt = '0;
        want.time_valid   = (st == ST_OK);
        want.status       = st;
        want.unix_seconds = secs64[30:0];
        want.microseconds = us64[19:0];
        expected_times.push_back(want);
    endtask

    task automatic queue_reply(input int len, input logic [7:0] hdr, input logic [7:0] strat,
                               input logic [31:0] sec, input logic [31:0] frac,
                               input logic [11:0] rtt, input bit settle);
        t_in_beat b;
        for (int p = 0; p < len; p++) begin
            b.payload_byte  = 8'($urandom);
            b.round_trip_ms = 12'($urandom);
            b.is_last       = (p == len - 1);
            if (p == 0) b.payload_byte = hdr;
            else if (p == 1) b.payload_byte = strat;
            else if (p >= 40 && p <= 43) b.payload_byte = sec[8 * (43 - p) +: 8];
            else if (p >= 44 && p <= 47) b.payload_byte = frac[8 * (47 - p) +: 8];
            if (b.is_last) b.round_trip_ms = rtt;
            reply_bytes.push_back(b);
            settle_first.push_back(settle && p == 0);
        end
    endtask

    task automatic report_miss(input string what, input t_out_beat want, input t_out_beat got);
        if (miss_cnt < 10) begin
            $display("%s: expected valid=%0d status=%0d sec=%0d us=%0d,",
                     what, want.time_valid, want.status, want.unix_seconds,
                     want.microseconds);
            $display("    got valid=%0d status=%0d sec=%0d us=%0d",
                     got.time_valid, got.status, got.unix_seconds, got.microseconds);
        end
        miss_cnt++;
    endtask

    // Sender: one beat per accepted handshake, with random gaps.
    always @(posedge i_clk) begin
        t_in_beat next_beat;
        logic     next_push;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                advance_reply_state(i_item);
                sent_cnt++;
            end
            if (!(push && full)) begin
                next_push = 1'b0;
                next_beat = i_item;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (reply_bytes.size() > 0 &&
                             !(settle_first[0] && expected_times.size() > 0)) begin
                    next_push = 1'b1;
                    next_beat = reply_bytes.pop_front();
                    void'(settle_first.pop_front());
                    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                        send_gap = $urandom_range(1, 15);
                    end
                end
                push   <= next_push;
                i_item <= next_beat;
            end
            quiet_tail <= (sent_cnt + TAIL_BEATS >= total_items);
        end
    end

    // Receiver: checks each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_times.size() == 0) begin
                    report_miss("result with nothing expected", '0, o_result);
                end else begin
                    want = expected_times.pop_front();
                    if (o_result.time_valid !== want.time_valid ||
                        o_result.status !== want.status ||
                        o_result.unix_seconds !== want.unix_seconds ||
                        o_result.microseconds !== want.microseconds) begin
                        report_miss("result mismatch", want, o_result);
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                    take_gap = $urandom_range(1, 15);
                end
            end
        end
    end

    // Idle density changes each time phase_cnt wraps, sometimes to none at all; a stall watchdog ends a hung test.
    always @(posedge i_clk) begin
        phase_cnt <= (phase_cnt + 1) % 256;
        if (phase_cnt == 0) begin
            case ($urandom_range(0, 3))
                0: idle_pct <= 0;
                1: idle_pct <= 5;
                2: idle_pct <= 20;
                default: idle_pct <= 50;
            endcase
        end
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int          n_replies;
        int          kind;
        int          len;
        logic [7:0]  hdr;
        logic [7:0]  strat;
        logic [31:0] sec;

        // Directed replies: length, mode, stratum and epoch corners.
        queue_reply(48, 8'h24, 8'd2, 32'he000_0000, 32'h8000_0000, 12'd40, 1'b0);
        queue_reply(1, 8'h24, 8'd1, 32'hFFFF_FFFF, 32'd0, 12'd0, 1'b0);
        queue_reply(47, 8'h24, 8'd1, 32'hE000_0000, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'h1B, 8'd1, 32'hE000_0000, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'h24, 8'd0, 32'hE000_0000, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'h24, 8'd16, 32'hE000_0000, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'hFC, 8'd255, 32'hE000_0000, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'h24, 8'd15, EPOCH_GAP_SECS - 32'd1, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'h24, 8'd1, 32'd0, 32'hFFFF_FFFF, 12'd4095, 1'b0);
        queue_reply(48, 8'h24, 8'd1, EPOCH_GAP_SECS, 32'd0, 12'd0, 1'b0);
        queue_reply(48, 8'hFC, 8'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd4095, 1'b0);
        queue_reply(60, 8'h24, 8'd1, 32'hE5A1_0000, 32'h1234_5678, 12'd2000, 1'b0);
        // Well past 63 bytes, so a wrapping byte count would show.
        queue_reply(130, 8'h24, 8'd3, 32'hE5A1_0001, 32'hFFFF_0000, 12'd1999, 1'b0);
        n_replies = 13;

        // Random replies: mostly well formed, the rest broken or noise.
        while (reply_bytes.size() < 1800 || n_replies < 48) begin
            kind = $urandom_range(0, 99);
            hdr  = {5'($urandom), MODE_SERVER};
            strat = 8'($urandom_range(1, 15));
            sec  = ($urandom_range(0, 7) == 0) ? EPOCH_GAP_SECS + 32'($urandom_range(0, 3))
                                                : $urandom_range(32'hFFFF_FFFF, EPOCH_GAP_SECS);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(48, 140)
                                                : $urandom_range(48, 52);
            if (kind >= 75) begin
                case ($urandom_range(0, 4))
                    0: len = $urandom_range(1, 47);
                    1: begin
                        hdr = 8'($urandom);
                        if (hdr[2:0] == MODE_SERVER) hdr[0] = 1'b1;
                    end
                    2: strat = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(16, 255));
                    3: sec = $urandom_range(EPOCH_GAP_SECS - 1, 0);
                    default: begin
                        hdr   = 8'($urandom);
                        strat = 8'($urandom);
                        sec   = $urandom;
                        len   = $urandom_range(1, 64);
                    end
                endcase
            end
            queue_reply(len, hdr, strat, sec, $urandom, 12'($urandom_range(0, 4095)),
                        n_replies == 13 || $urandom_range(0, 19) == 0);
            n_replies++;
        end
        total_items = reply_bytes.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (reply_bytes.size() > 0 || push || expected_times.size() > 0);
        repeat (10) @(posedge i_clk);

        if (miss_cnt == 0 && expected_times.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/ntp_rte_pkg.sv
design/ntp_rte_front.sv
design/ntp_rte_queue.sv
design/ntp_rte_back.sv
design/ntp_reply_time_extractor.sv
bench/tb_top.sv
